>>> rtl/dpr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the debug packet receiver.
package dpr_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 9;
    localparam int START_W    = 2;
    localparam int KIND_W     = 2;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ACK   = 8'h2B;
    localparam logic [7:0] CH_NAK   = 8'h2D;
    localparam logic [7:0] CH_SEQ   = 8'h3A;

    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [START_W-1:0] START_NONE = 2'd0;
    localparam logic [START_W-1:0] START_SEQ  = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_DATA,
        PH_CK_HI,
        PH_CK_LO
    } phase_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_NAK,
        CMD_ACK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic       flag;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_HEAD,
        BK_SEQ_A,
        BK_SEQ_B,
        BK_REPORT
    } back_state_t;

endpackage

>>> rtl/debug_packet_receiver.sv
`timescale 1ns / 1ps
// Debug link packet receiver: '$' payload '#' hex-checksum framing with ack/nak and buffer reads.
// The receiver takes one input transaction per cycle while its command queue has room.
// The front end classifies each character in the cycle it arrives and queues at most one
// command; the back end carries out one command step per cycle while its result stages can
// advance: a read yields a byte, a bad packet '-', a good packet '+', the sequence id bytes
// when echoed and the report; a stored byte yields nothing. Results pass a staging register
// and then the output register. The payload buffer is a single-port-write, single-port-read
// memory of BUFFER_BYTES entries with no clearing pass; only bytes of the accepted packet
// are ever read back, so the block takes input straight out of reset.
module debug_packet_receiver #(
    parameter int BUFFER_BYTES = dpr_pkg::BUFFER_BYTES_DEF,
    parameter int QUEUE_DEPTH  = dpr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dpr_pkg::IN_DATA_W-1:0]   s_tdata,   // rx_char[7:0], read_index[16:8], zero pad
    input  logic                            s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dpr_pkg::OUT_DATA_W-1:0]  m_tdata,   // out_char[7:0], payload_start[9:8],
                                                       // payload_length[18:10], zero pad
    output logic [dpr_pkg::KIND_W-1:0]      m_tuser,   // kind
    output logic                            m_tlast    // last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int QW = $bits(dpr_pkg::cmd_t) + AW;

    logic          push;
    dpr_pkg::cmd_t push_cmd;
    logic [AW-1:0] push_addr;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    dpr_pkg::cmd_t head_cmd;
    logic [AW-1:0] head_addr;

    assign head_cmd  = dpr_pkg::cmd_t'(q_data[QW-1:AW]);
    assign head_addr = q_data[AW-1:0];

    dpr_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (push),
        .q_cmd    (push_cmd),
        .q_addr   (push_addr)
    );

    dpr_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (QW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_cmd, push_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    dpr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_addr   (head_addr),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/dpr_front.sv
`timescale 1ns / 1ps
// Front end: parses link characters and read requests into queued commands.
module dpr_front #(
    parameter int BUFFER_BYTES = dpr_pkg::BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpr_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output dpr_pkg::cmd_t                 q_cmd,
    output logic [AW-1:0]                 q_addr
);

    localparam int CW = (AW > dpr_pkg::IDX_W) ? AW : dpr_pkg::IDX_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_BYTES - 1);

    dpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]    sum_reg, sum_next;
    logic [AW-1:0] count_reg, count_next;
    logic [4:0]    hi_reg, hi_next;
    logic [AW-1:0] acc_len_reg, acc_len_next;
    logic [7:0]    seq_a_reg, seq_a_next;
    logic [7:0]    seq_b_reg, seq_b_next;
    logic          colon_reg, colon_next;

    logic                        accept;
    logic [7:0]                  rx_char;
    logic [dpr_pkg::IDX_W-1:0]   read_index;
    logic [4:0]                  lo_digit;
    logic                        count_full;
    logic                        seq_ok;
    logic                        ck_ok;
    logic                        idx_hit;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && !q_full;
    assign rx_char    = s_tdata[7:0];
    assign read_index = s_tdata[16:8];
    assign lo_digit   = hex_digit(rx_char);
    assign count_full = count_reg >= LAST_SLOT;
    assign seq_ok     = (count_reg >= AW'(3)) && colon_reg;
    assign ck_ok      = !hi_reg[4] && !lo_digit[4] && ({hi_reg[3:0], lo_digit[3:0]} == sum_reg);
    assign idx_hit    = CW'(read_index) < CW'(acc_len_reg);

    always_comb begin
        phase_next = phase_reg;
        if (accept && !s_tuser) begin
            case (phase_reg)
                dpr_pkg::PH_HUNT: begin
                    if (rx_char == dpr_pkg::CH_START) begin
                        phase_next = dpr_pkg::PH_DATA;
                    end
                end
                dpr_pkg::PH_DATA: begin
                    if (rx_char == dpr_pkg::CH_START) begin
                        phase_next = dpr_pkg::PH_DATA;
                    end else if (rx_char == dpr_pkg::CH_END) begin
                        phase_next = dpr_pkg::PH_CK_HI;
                    end else if (count_full) begin
                        phase_next = dpr_pkg::PH_HUNT;
                    end
                end
                dpr_pkg::PH_CK_HI: phase_next = dpr_pkg::PH_CK_LO;
                dpr_pkg::PH_CK_LO: phase_next = dpr_pkg::PH_HUNT;
                default:           phase_next = dpr_pkg::PH_HUNT;
            endcase
        end
    end

    always_comb begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        hi_next      = hi_reg;
        acc_len_next = acc_len_reg;
        seq_a_next   = seq_a_reg;
        seq_b_next   = seq_b_reg;
        colon_next   = colon_reg;
        q_push       = 1'b0;
        q_cmd        = '{op: dpr_pkg::CMD_WRITE, byte_a: 8'h00, byte_b: 8'h00, flag: 1'b0};
        q_addr       = '0;
        if (accept) begin
            if (s_tuser) begin
                q_push      = 1'b1;
                q_cmd.op    = dpr_pkg::CMD_READ;
                q_cmd.flag  = idx_hit;
                q_addr      = AW'(read_index);
            end else begin
                case (phase_reg)
                    dpr_pkg::PH_HUNT: begin
                        if (rx_char == dpr_pkg::CH_START) begin
                            sum_next     = '0;
                            count_next   = '0;
                            acc_len_next = '0;
                        end
                    end
                    dpr_pkg::PH_DATA: begin
                        if (rx_char == dpr_pkg::CH_START) begin
                            sum_next   = '0;
                            count_next = '0;
                        end else if (rx_char == dpr_pkg::CH_END) begin
                            sum_next = sum_reg;
                        end else if (count_full) begin
                            sum_next   = '0;
                            count_next = '0;
                        end else begin
                            q_push       = 1'b1;
                            q_cmd.op     = dpr_pkg::CMD_WRITE;
                            q_cmd.byte_a = rx_char;
                            q_addr       = count_reg;
                            count_next   = count_reg + AW'(1);
                            sum_next     = sum_reg + rx_char;
                            if (count_reg == AW'(0)) begin
                                seq_a_next = rx_char;
                            end
                            if (count_reg == AW'(1)) begin
                                seq_b_next = rx_char;
                            end
                            if (count_reg == AW'(2)) begin
                                colon_next = rx_char == dpr_pkg::CH_SEQ;
                            end
                        end
                    end
                    dpr_pkg::PH_CK_HI: begin
                        hi_next = lo_digit;
                    end
                    dpr_pkg::PH_CK_LO: begin
                        q_push = 1'b1;
                        if (ck_ok) begin
                            q_cmd.op     = dpr_pkg::CMD_ACK;
                            q_cmd.flag   = seq_ok;
                            q_cmd.byte_a = seq_a_reg;
                            q_cmd.byte_b = seq_b_reg;
                            q_addr       = count_reg;
                            acc_len_next = count_reg;
                        end else begin
                            q_cmd.op = dpr_pkg::CMD_NAK;
                        end
                        sum_next   = '0;
                        count_next = '0;
                        hi_next    = '0;
                    end
                    default: begin
                        sum_next = sum_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= dpr_pkg::PH_HUNT;
            sum_reg     <= '0;
            count_reg   <= '0;
            hi_reg      <= '0;
            acc_len_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            hi_reg      <= hi_next;
            acc_len_reg <= acc_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_a_reg <= seq_a_next;
        seq_b_reg <= seq_b_next;
        colon_reg <= colon_next;
    end

endmodule

>>> rtl/dpr_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module dpr_fifo #(
    parameter int DEPTH = dpr_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_FULL;
    assign valid    = count_reg != '0;
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dpr_back.sv
`timescale 1ns / 1ps
// Back end: payload buffer, command execution and result output register.
module dpr_back #(
    parameter int BUFFER_BYTES = dpr_pkg::BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  dpr_pkg::cmd_t                   q_cmd,
    input  logic [AW-1:0]                   q_addr,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dpr_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [dpr_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    localparam int PAD_W = dpr_pkg::OUT_DATA_W - 8 - dpr_pkg::START_W - dpr_pkg::LEN_W;

    logic [7:0] buf_mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    dpr_pkg::back_state_t state_reg, state_next;

    logic                          a_valid_reg;
    logic [dpr_pkg::KIND_W-1:0]    a_kind_reg;
    logic [7:0]                    a_char_reg;
    logic [dpr_pkg::START_W-1:0]   a_start_reg;
    logic [dpr_pkg::LEN_W-1:0]     a_len_reg;
    logic                          a_last_reg;
    logic                          a_mem_reg;

    logic                          m_valid_reg;
    logic [dpr_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [dpr_pkg::KIND_W-1:0]    m_kind_reg;
    logic                          m_last_reg;

    logic                          out_free;
    logic                          a_free;
    logic                          step;
    logic                          res_load;
    logic [dpr_pkg::KIND_W-1:0]    res_kind;
    logic [7:0]                    res_char;
    logic [dpr_pkg::START_W-1:0]   res_start;
    logic [dpr_pkg::LEN_W-1:0]     res_len;
    logic                          res_last;
    logic                          res_mem;
    logic                          mem_we;
    logic                          mem_re;

    assign out_free = !m_valid_reg || m_tready;
    assign a_free   = !a_valid_reg || out_free;
    assign step     = q_valid && a_free;

    always_comb begin
        state_next = state_reg;
        if (step) begin
            case (state_reg)
                dpr_pkg::BK_HEAD: begin
                    if (q_cmd.op == dpr_pkg::CMD_ACK) begin
                        state_next = q_cmd.flag ? dpr_pkg::BK_SEQ_A : dpr_pkg::BK_REPORT;
                    end
                end
                dpr_pkg::BK_SEQ_A:  state_next = dpr_pkg::BK_SEQ_B;
                dpr_pkg::BK_SEQ_B:  state_next = dpr_pkg::BK_REPORT;
                dpr_pkg::BK_REPORT: state_next = dpr_pkg::BK_HEAD;
                default:            state_next = dpr_pkg::BK_HEAD;
            endcase
        end
    end

    always_comb begin
        res_load  = 1'b0;
        res_kind  = dpr_pkg::KIND_CHAR;
        res_char  = 8'h00;
        res_start = dpr_pkg::START_NONE;
        res_len   = '0;
        res_last  = 1'b0;
        res_mem   = 1'b0;
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (step) begin
            case (state_reg)
                dpr_pkg::BK_HEAD: begin
                    case (q_cmd.op)
                        dpr_pkg::CMD_WRITE: begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        dpr_pkg::CMD_READ: begin
                            res_load = 1'b1;
                            res_kind = dpr_pkg::KIND_READ;
                            res_mem  = q_cmd.flag;
                            mem_re   = q_cmd.flag;
                            res_last = 1'b1;
                            q_pop    = 1'b1;
                        end
                        dpr_pkg::CMD_NAK: begin
                            res_load = 1'b1;
                            res_char = dpr_pkg::CH_NAK;
                            res_last = 1'b1;
                            q_pop    = 1'b1;
                        end
                        dpr_pkg::CMD_ACK: begin
                            res_load = 1'b1;
                            res_char = dpr_pkg::CH_ACK;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
                dpr_pkg::BK_SEQ_A: begin
                    res_load = 1'b1;
                    res_char = q_cmd.byte_a;
                end
                dpr_pkg::BK_SEQ_B: begin
                    res_load = 1'b1;
                    res_char = q_cmd.byte_b;
                end
                dpr_pkg::BK_REPORT: begin
                    res_load  = 1'b1;
                    res_kind  = dpr_pkg::KIND_ACCEPT;
                    res_start = q_cmd.flag ? dpr_pkg::START_SEQ : dpr_pkg::START_NONE;
                    res_len   = dpr_pkg::LEN_W'(q_addr);
                    res_last  = 1'b1;
                    q_pop     = 1'b1;
                end
                default: begin
                    res_load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[q_addr] <= q_cmd.byte_a;
        end
        if (mem_re) begin
            rd_data_reg <= buf_mem[q_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dpr_pkg::BK_HEAD;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (a_free) begin
                a_valid_reg <= res_load;
            end
            if (out_free) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free && res_load) begin
            a_kind_reg  <= res_kind;
            a_char_reg  <= res_char;
            a_start_reg <= res_start;
            a_len_reg   <= res_len;
            a_last_reg  <= res_last;
            a_mem_reg   <= res_mem;
        end
        if (out_free && a_valid_reg) begin
            m_data_reg <= {PAD_W'(0), a_len_reg, a_start_reg,
                           a_mem_reg ? rd_data_reg : a_char_reg};
            m_kind_reg <= a_kind_reg;
            m_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/dpr_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the debug packet receiver, bound to the top level.
module dpr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dpr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [dpr_pkg::KIND_W-1:0]      m_tuser,
    input logic                            m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_accept_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dpr_pkg::KIND_ACCEPT |-> m_tlast && m_tdata[7:0] == 8'h00)
        else $error("packet report not final or carries a character");

    a_read_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dpr_pkg::KIND_READ |-> m_tlast && m_tdata[23:8] == 16'h0000)
        else $error("read result malformed");

    a_char_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == dpr_pkg::KIND_CHAR |-> m_tdata[23:8] == 16'h0000)
        else $error("character result carries packet fields");

endmodule

bind debug_packet_receiver dpr_checker u_dpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of debug_packet_receiver: framed link traffic, buffer reads, random idling.

typedef logic [7:0] byte_q_t [$];

typedef struct packed {
    logic [dpr_pkg::KIND_W-1:0]  kind;
    logic [7:0]                  ch;
    logic [dpr_pkg::START_W-1:0] start;
    logic [dpr_pkg::LEN_W-1:0]   len;
    logic                        last;
} link_result_t;

class link_scoreboard;
    dpr_pkg::phase_t           phase;
    logic [7:0]                frame_sum;
    logic [dpr_pkg::LEN_W-1:0] frame_count;
    logic [4:0]                sum_high_digit;
    logic [dpr_pkg::LEN_W-1:0] accepted_len;
    logic [7:0]                payload_mem [dpr_pkg::BUFFER_BYTES_DEF];
    link_result_t              expected_q [$];
    int                        failures;

    function new();
        phase          = dpr_pkg::PH_HUNT;
        frame_sum      = '0;
        frame_count    = '0;
        sum_high_digit = '0;
        accepted_len   = '0;
        failures       = 0;
        foreach (payload_mem[i]) payload_mem[i] = 8'h00;
    endfunction

    function logic [4:0] digit_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    function void push_result(logic [dpr_pkg::KIND_W-1:0] kind, logic [7:0] ch,
                              logic [dpr_pkg::START_W-1:0] start,
                              logic [dpr_pkg::LEN_W-1:0] len);
        link_result_t r;
        r = '{kind: kind, ch: ch, start: start, len: len, last: 1'b0};
        expected_q.push_back(r);
    endfunction

    function void note_input(bit is_read, logic [7:0] c, logic [dpr_pkg::IDX_W-1:0] idx);
        int                          base;
        logic [4:0]                  low_digit;
        logic [dpr_pkg::START_W-1:0] start;
        bit                          sum_ok;
        base = expected_q.size();
        if (is_read) begin
            push_result(dpr_pkg::KIND_READ, (idx < accepted_len) ? payload_mem[idx] : 8'h00,
                        dpr_pkg::START_NONE, '0);
        end else begin
            case (phase)
                dpr_pkg::PH_HUNT: begin
                    if (c == dpr_pkg::CH_START) begin
                        phase        = dpr_pkg::PH_DATA;
                        frame_sum    = '0;
                        frame_count  = '0;
                        accepted_len = '0;
                    end
                end
                dpr_pkg::PH_DATA: begin
                    if (c == dpr_pkg::CH_START) begin
                        frame_sum   = '0;
                        frame_count = '0;
                    end else if (c == dpr_pkg::CH_END) begin
                        phase = dpr_pkg::PH_CK_HI;
                    end else if (frame_count >=
                                 dpr_pkg::LEN_W'(dpr_pkg::BUFFER_BYTES_DEF - 1)) begin
                        phase       = dpr_pkg::PH_HUNT;
                        frame_sum   = '0;
                        frame_count = '0;
                    end else begin
                        payload_mem[frame_count] = c;
                        frame_count = frame_count + 1'b1;
                        frame_sum   = frame_sum + c;
                    end
                end
                dpr_pkg::PH_CK_HI: begin
                    sum_high_digit = digit_of(c);
                    phase          = dpr_pkg::PH_CK_LO;
                end
                default: begin
                    low_digit = digit_of(c);
                    sum_ok = !sum_high_digit[4] && !low_digit[4] &&
                             ({sum_high_digit[3:0], low_digit[3:0]} == frame_sum);
                    phase = dpr_pkg::PH_HUNT;
                    if (!sum_ok) begin
                        push_result(dpr_pkg::KIND_CHAR, dpr_pkg::CH_NAK,
                                    dpr_pkg::START_NONE, '0);
                    end else begin
                        start = dpr_pkg::START_NONE;
                        push_result(dpr_pkg::KIND_CHAR, dpr_pkg::CH_ACK,
                                    dpr_pkg::START_NONE, '0);
                        if (frame_count >= 3 && payload_mem[2] == dpr_pkg::CH_SEQ) begin
                            push_result(dpr_pkg::KIND_CHAR, payload_mem[0],
                                        dpr_pkg::START_NONE, '0);
                            push_result(dpr_pkg::KIND_CHAR, payload_mem[1],
                                        dpr_pkg::START_NONE, '0);
                            start = dpr_pkg::START_SEQ;
                        end
                        accepted_len = frame_count;
                        push_result(dpr_pkg::KIND_ACCEPT, 8'h00, start, frame_count);
                    end
                    frame_sum      = '0;
                    frame_count    = '0;
                    sum_high_digit = '0;
                end
            endcase
        end
        if (expected_q.size() > base) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(link_result_t got);
        link_result_t want;
        if (expected_q.size() == 0) begin
            if (failures < 10)
                $display("unexpected result: kind=%0d char=%02h start=%0d len=%0d last=%0b",
                         got.kind, got.ch, got.start, got.len, got.last);
            failures++;
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            if (failures < 10)
                $display("mismatch: expected kind=%0d char=%02h start=%0d len=%0d last=%0b, %s",
                         want.kind, want.ch, want.start, want.len, want.last,
                         $sformatf("got kind=%0d char=%02h start=%0d len=%0d last=%0b",
                                   got.kind, got.ch, got.start, got.len, got.last));
            failures++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_top;
    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dpr_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [dpr_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic [dpr_pkg::KIND_W-1:0]      m_tuser;
    logic                            m_tlast;

    link_scoreboard frames = new();
    bit             quiet = 1'b0;
    int             stimulus_items = 0;

    debug_packet_receiver i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            frames.check_result('{kind: m_tuser, ch: m_tdata[7:0], start: m_tdata[9:8],
                                  len: m_tdata[18:10], last: m_tlast});
    end

    initial begin
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    task automatic send_item(input bit is_read, input logic [7:0] c,
                             input logic [dpr_pkg::IDX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_read;
        s_tdata  <= {7'd0, idx, c};
        do @(posedge aclk); while (!s_tready);
        if (is_read || frames.phase != dpr_pkg::PH_HUNT || c == dpr_pkg::CH_START)
            stimulus_items++;
        frames.note_input(is_read, c, idx);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(1'b0, c, dpr_pkg::IDX_W'($urandom_range(0, 511)));
    endtask

    task automatic read_byte(input logic [dpr_pkg::IDX_W-1:0] idx);
        send_item(1'b1, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frames.pending() != 0);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 10) return "0" + 8'(v);
        return (upper ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    function automatic byte_q_t random_body(int len, bit with_seq);
        byte_q_t    body;
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            do b = 8'($urandom); while (b == dpr_pkg::CH_START || b == dpr_pkg::CH_END);
            body.push_back(b);
        end
        if (with_seq && len >= 3) body[2] = dpr_pkg::CH_SEQ;
        return body;
    endfunction

    task automatic send_frame(input byte_q_t body, input logic [7:0] ck_hi,
                              input logic [7:0] ck_lo);
        send_char(dpr_pkg::CH_START);
        foreach (body[i]) send_char(body[i]);
        send_char(dpr_pkg::CH_END);
        send_char(ck_hi);
        send_char(ck_lo);
    endtask

    task automatic send_checked_frame(input byte_q_t body, input bit upper);
        logic [7:0] sum;
        sum = '0;
        foreach (body[i]) sum += body[i];
        send_frame(body, hex_char(sum[7:4], upper), hex_char(sum[3:0], upper));
    endtask

    initial begin
        byte_q_t    none;
        byte_q_t    body;
        byte_q_t    one;
        logic [7:0] c;
        bit         drained;
        int         len;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        aresetn  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        read_byte(0);
        read_byte(511);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(dpr_pkg::CH_END);
        send_checked_frame('{"a", "b"}, 1'b0);
        read_byte(0);
        read_byte(1);
        read_byte(2);
        send_checked_frame('{"0", "1", dpr_pkg::CH_SEQ, "m"}, 1'b1);
        read_byte(3);
        send_checked_frame('{"x", dpr_pkg::CH_SEQ}, 1'b0);
        send_checked_frame(none, 1'b0);
        send_checked_frame('{8'h00, 8'hFF, 8'h80}, 1'b1);
        send_frame('{"q"}, "0", "0");
        send_frame('{"g"}, "6", "g");
        send_frame('{"Z"}, dpr_pkg::CH_START, "A");
        read_byte(0);
        send_char(dpr_pkg::CH_START);
        send_char("x");
        send_char("y");
        send_checked_frame('{"o", "k"}, 1'b0);
        read_byte(1);

        send_checked_frame(random_body(dpr_pkg::BUFFER_BYTES_DEF - 1, 1'b1), 1'b0);
        read_byte(dpr_pkg::IDX_W'(dpr_pkg::BUFFER_BYTES_DEF - 2));
        read_byte(dpr_pkg::IDX_W'(dpr_pkg::BUFFER_BYTES_DEF - 1));
        send_checked_frame(random_body(dpr_pkg::BUFFER_BYTES_DEF, 1'b0), 1'b1);
        read_byte(0);
        wait_for_results();

        stimulus_items = 0;
        drained = 1'b0;
        while (stimulus_items < 180) begin
            if (stimulus_items > 150) quiet = 1'b1;
            if (!drained && stimulus_items >= 90) begin
                wait_for_results();
                drained = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            body = random_body(len, $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 4) != 0)
                        send_checked_frame(body, $urandom_range(0, 1));
                    else
                        send_frame(body, hex_char(4'($urandom), 1'b0),
                                   hex_char(4'($urandom), 1'b1));
                end
                5, 6: begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 3) == 0)
                            read_byte(dpr_pkg::IDX_W'($urandom_range(0, 511)));
                        else
                            read_byte(dpr_pkg::IDX_W'($urandom_range(0,
                                                      frames.accepted_len + 2)));
                    end
                end
                7: begin
                    repeat ($urandom_range(1, 3)) begin
                        do c = 8'($urandom); while (c == dpr_pkg::CH_START);
                        send_char(c);
                    end
                end
                8: begin
                    send_char(dpr_pkg::CH_START);
                    repeat ($urandom_range(0, 4)) begin
                        one = random_body(1, 1'b0);
                        send_char(one[0]);
                    end
                    send_checked_frame(body, $urandom_range(0, 1));
                end
                default: begin
                    send_frame(body,
                               ($urandom_range(0, 3) == 0) ? dpr_pkg::CH_START : 8'($urandom),
                               8'($urandom));
                end
            endcase
        end

        s_tvalid <= 1'b0;
        while (frames.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (frames.failures == 0 && frames.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end
endmodule
